// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// cause in one cycle implies effect in the next
`define ASSERT_NEXT(lbl, clk_s, rst_s, cause, effect, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cause) |=> (effect)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, cause, effect, msg)

`endif

`endif

// File: hw/rtl/trp_pkg.sv
package trp_pkg;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  localparam logic [7:0] T_SE   = 8'd240;
  localparam logic [7:0] T_BRK  = 8'd243;
  localparam logic [7:0] T_IP   = 8'd244;
  localparam logic [7:0] T_AO   = 8'd245;
  localparam logic [7:0] T_AYT  = 8'd246;
  localparam logic [7:0] T_EC   = 8'd247;
  localparam logic [7:0] T_EL   = 8'd248;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_IAC  = 8'd255;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_OPT   = 3'd1;
  localparam logic [2:0] KIND_SBEND = 3'd2;
  localparam logic [2:0] KIND_IP    = 3'd3;
  localparam logic [2:0] KIND_BRK   = 3'd4;
  localparam logic [2:0] KIND_AYT   = 3'd5;

  localparam logic [7:0] REG_ERASE    = 8'd0;
  localparam logic [7:0] REG_KILL     = 8'd1;
  localparam logic [7:0] REG_DISCARD  = 8'd2;
  localparam logic [7:0] REG_DISABLED = 8'd3;

  localparam logic [7:0] ERASE_RESET    = 8'd127;
  localparam logic [7:0] KILL_RESET     = 8'd21;
  localparam logic [7:0] DISCARD_RESET  = 8'd15;
  localparam logic [7:0] DISABLED_RESET = 8'd0;

  // result queue depth; a byte gives at most two results
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_CR      = 3'd1,
    MODE_IAC     = 3'd2,
    MODE_OPT     = 3'd3,
    MODE_SB_OPT  = 3'd4,
    MODE_SB_DATA = 3'd5,
    MODE_SB_IAC  = 3'd6
  } mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] option_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] discard_char;
    logic [7:0] disabled_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: hw/rtl/trp_parser.sv
module trp_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  trp_pkg::cfg_t cfg,
  output trp_pkg::push_t push
);
  import trp_pkg::*;

  mode_t      mode, mode_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_option, held_option_next;
  logic [7:0] ctrl_ch;

  function automatic res_t mk(logic [2:0] k, logic [7:0] v, logic [7:0] o, logic l);
    res_t r;
    r.kind        = k;
    r.value       = v;
    r.option_code = o;
    r.last        = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      held_command <= '0;
      held_option  <= '0;
    end else if (step) begin
      mode         <= mode_next;
      held_command <= held_command_next;
      held_option  <= held_option_next;
    end
  end

  always_comb begin
    priority if (rx_byte == T_EC) ctrl_ch = cfg.erase_char;
    else if (rx_byte == T_EL)     ctrl_ch = cfg.kill_char;
    else                          ctrl_ch = cfg.discard_char;
  end

  always_comb begin
    mode_next         = MODE_NORMAL;
    held_command_next = held_command;
    held_option_next  = held_option;
    push.count        = 2'd0;
    push.r0           = mk(KIND_DATA, rx_byte, 8'd0, 1'b1);
    push.r1           = mk(KIND_DATA, rx_byte, 8'd0, 1'b1);
    unique case (mode)
      MODE_CR: begin
        push.count = 2'd1;
        if (rx_byte == CH_LF) begin
          push.r0 = mk(KIND_DATA, CH_LF, 8'd0, 1'b1);
        end else if (rx_byte == CH_NUL) begin
          push.r0 = mk(KIND_DATA, CH_CR, 8'd0, 1'b1);
        end else if (rx_byte == T_IAC) begin
          push.r0   = mk(KIND_DATA, CH_CR, 8'd0, 1'b1);
          mode_next = MODE_IAC;
        end else begin
          push.count = 2'd2;
          push.r0    = mk(KIND_DATA, CH_CR, 8'd0, 1'b0);
        end
      end
      MODE_IAC: begin
        unique case (rx_byte)
          T_IAC: push.count = 2'd1;
          T_WILL, T_WONT, T_DO, T_DONT: begin
            held_command_next = rx_byte;
            mode_next         = MODE_OPT;
          end
          T_SB: mode_next = MODE_SB_OPT;
          T_IP: begin
            push.count = 2'd1;
            push.r0    = mk(KIND_IP, 8'd0, 8'd0, 1'b1);
          end
          T_BRK: begin
            push.count = 2'd1;
            push.r0    = mk(KIND_BRK, 8'd0, 8'd0, 1'b1);
          end
          T_AYT: begin
            push.count = 2'd1;
            push.r0    = mk(KIND_AYT, 8'd0, 8'd0, 1'b1);
          end
          T_EC, T_EL, T_AO: begin
            push.count = (ctrl_ch == cfg.disabled_code) ? 2'd0 : 2'd1;
            push.r0    = mk(KIND_DATA, ctrl_ch, 8'd0, 1'b1);
          end
          default: push.count = 2'd0;
        endcase
      end
      MODE_OPT: begin
        push.count = 2'd1;
        push.r0    = mk(KIND_OPT, held_command, rx_byte, 1'b1);
      end
      MODE_SB_OPT: begin
        held_option_next = rx_byte;
        mode_next        = MODE_SB_DATA;
      end
      MODE_SB_DATA: begin
        mode_next = (rx_byte == T_IAC) ? MODE_SB_IAC : MODE_SB_DATA;
      end
      MODE_SB_IAC: begin
        if (rx_byte == T_SE) begin
          push.count = 2'd1;
          push.r0    = mk(KIND_SBEND, 8'd0, held_option, 1'b1);
        end else begin
          mode_next = MODE_SB_DATA;
        end
      end
      default: begin
        // normal mode, and the one unused code
        if (rx_byte == CH_CR)       mode_next = MODE_CR;
        else if (rx_byte == T_IAC)  mode_next = MODE_IAC;
        else                        push.count = 2'd1;
      end
    endcase
    if (!step) push.count = 2'd0;
  end

endmodule

// File: hw/rtl/trp_out_fifo.sv
module trp_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  trp_pkg::push_t push,
  output logic           room2,
  output logic           out_valid,
  input  logic           out_ready,
  output trp_pkg::res_t  head
);
  import trp_pkg::*;

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic [PTR_W-1:0] wptr_inc;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign head      = mem[rptr];
  assign room2     = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign wptr_inc  = wptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wptr] <= push.r0;
    if (push.count == 2'd2) mem[wptr_inc] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      if (pop) rptr <= rptr + PTR_W'(1);
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

// File: hw/rtl/telnet_receive_parser.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | rx_byte
// out     | output    | out_valid / out_ready | kind, value, option_code, last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while two queue entries are free: a byte is held in the
// input register, is parsed in one pass and lands in a four-entry result queue
// at the next edge, and the queue head drives the result beat.
// A byte is parsed only while two queue entries are free; a stalled output
// side holds the input until the queue drains to two entries.
// Reset empties the queue, returns the parser to normal data mode and loads
// the control character registers with their defaults. cfg_ready is always high.
module telnet_receive_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic [7:0] option_code,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import trp_pkg::*;
  `include "assert_macros.svh"

  cfg_t       cfg;
  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       room2;
  logic       step;
  push_t      push;
  res_t       head;

  assign cfg_ready = 1'b1;
  assign step      = ib_valid && room2;
  assign in_ready  = !ib_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.erase_char    <= ERASE_RESET;
      cfg.kill_char     <= KILL_RESET;
      cfg.discard_char  <= DISCARD_RESET;
      cfg.disabled_code <= DISABLED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ERASE:    cfg.erase_char    <= cfg_data;
        REG_KILL:     cfg.kill_char     <= cfg_data;
        REG_DISCARD:  cfg.discard_char  <= cfg_data;
        REG_DISABLED: cfg.disabled_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_ready) begin
      ib_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) ib_byte <= rx_byte;
  end

  trp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (ib_byte),
    .cfg     (cfg),
    .push    (push)
  );

  trp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind        = head.kind;
  assign value       = head.value;
  assign option_code = head.option_code;
  assign last        = head.last;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_ALWAYS(a_kind_range, clk, rst, !out_valid || kind <= KIND_AYT, "kind out of range")
  `ASSERT_ALWAYS(a_opt_zero, clk, rst, !out_valid || kind == KIND_OPT || kind == KIND_SBEND || option_code == 8'd0, "option_code set on non-option result")
  `ASSERT_ALWAYS(a_no_parse_full, clk, rst, !step || room2, "byte parsed without queue room")

endmodule
